### hw/rtl/tnc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the threshold neighbor count block.
// No dependencies.

package tnc_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESHOLD    = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;

  localparam int          RESET_SIZE      = 16;
  localparam logic [7:0]  RESET_THRESHOLD = 8'd127;

  typedef struct packed {
    logic [7:0] chan_a;
    logic [7:0] chan_b;
    logic [7:0] chan_c;
    logic       pad;
  } pixel_t;

  typedef struct packed {
    logic        cell_set;
    logic [3:0]  neighbour_count;
    logic [7:0]  cell_col;
    logic [7:0]  cell_row;
    logic        frame_last;
    logic [16:0] set_total;
  } result_t;

endpackage

### hw/rtl/threshold_neighbor_count_core.sv
`timescale 1ns / 1ps
// A cell's result is registered in stage 1, then queued, after the item completing its
// 3x3 window (frame_width+1 items after the cell's pixel) is taken. One item per cycle
// unless the queue is full; the line memory is read and written once per item. Reset
// clears the counters, pipeline and result queue and loads register defaults; the line
// memory is not cleared, rows outside the frame are masked instead.
module threshold_neighbor_count_core
  import tnc_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_ready,
  input  pixel_t                 pixel,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH + 1);   // frame width register
  localparam int HW  = $clog2(MAX_HEIGHT + 1);  // frame height register
  localparam int XW  = $clog2(MAX_WIDTH);       // column index
  localparam int RW  = $clog2(MAX_HEIGHT + 2);  // input row, runs to height+1 in flush
  localparam int ORW = $clog2(MAX_HEIGHT);      // output row
  localparam logic [CW-1:0] RESET_W =
    CW'((RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : RESET_SIZE);
  localparam logic [HW-1:0] RESET_H =
    HW'((RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : RESET_SIZE);

  // configuration
  logic [CW-1:0]  frame_w;
  logic [HW-1:0]  frame_h;
  logic [7:0]     threshold;
  logic           cfg_write;
  logic           size_write;
  logic [CW-1:0]  w_clamped;
  logic [HW-1:0]  h_clamped;

  // input side counters
  logic [XW-1:0]  vcol;
  logic [RW-1:0]  vrow;
  logic [XW-1:0]  out_col;
  logic [ORW-1:0] out_row;
  logic [16:0]    set_counter;

  logic           accept;
  logic           take;
  logic           pixel_phase;
  logic           emit;
  logic           last;
  logic [9:0]     chan_sum;
  logic [9:0]     set_limit;
  logic           set_now;
  logic           col_wrap;
  logic           fwd_next;

  // line memory: per column, {row y-1, row y-2} set flags
  logic [1:0]     line_mem [MAX_WIDTH];
  logic [1:0]     mem_rdata;
  logic [1:0]     mem_wdata;

  // stage 1
  logic           s1_valid;
  logic           s1_set;
  logic [XW-1:0]  s1_addr;
  logic           s1_emit;
  logic           s1_last;
  logic [7:0]     s1_col;
  logic [7:0]     s1_row;
  logic [16:0]    s1_total;
  logic           s1_left;
  logic           s1_right;
  logic           s1_top;
  logic           s1_bottom;
  logic           s1_fwd;
  logic [1:0]     s1_fwd_data;

  logic [1:0]     rd;
  logic [2:0]     new_col;
  logic [2:0]     col_p1;
  logic [2:0]     col_p2;
  logic [2:0]     row_mask;
  logic [2:0]     lm;
  logic [2:0]     rm;
  logic [2:0]     mm;
  logic [3:0]     nb_count;
  logic           own;
  result_t        res;

  // result queue
  result_t        fifo [3];
  logic [1:0]     wr_ptr;
  logic [1:0]     rd_ptr;
  logic [1:0]     q_count;
  logic           push;
  logic           pop;

  // ---------------- configuration ----------------
  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign size_write = cfg_write &&
                      (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  always_comb begin
    if (cfg_data == '0) begin
      w_clamped = CW'(1);
      h_clamped = HW'(1);
    end else begin
      w_clamped = (cfg_data > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(cfg_data);
      h_clamped = (cfg_data > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_w   <= RESET_W;
      frame_h   <= RESET_H;
      threshold <= RESET_THRESHOLD;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_w   <= w_clamped;
        REG_FRAME_HEIGHT: frame_h   <= h_clamped;
        REG_THRESHOLD:    threshold <= cfg_data[7:0];
        default:          ;
      endcase
    end
  end

  // ---------------- stage 0: counters and threshold ----------------
  assign accept      = pixel_valid && pixel_ready;
  assign pixel_phase = vrow < RW'(frame_h);
  // a pad item before the frame's last pixel is dropped
  assign take        = accept && !(pixel_phase && pixel.pad);

  // mean > t  <=>  sum > 3t+2
  assign chan_sum  = 10'(pixel.chan_a) + 10'(pixel.chan_b) + 10'(pixel.chan_c);
  assign set_limit = 10'({threshold, 1'b0}) + 10'(threshold) + 10'd2;
  assign set_now   = pixel_phase && (chan_sum > set_limit);

  // item k reports cell k-(width+1)
  assign emit     = (vrow >= RW'(2)) || (vrow == RW'(1) && vcol != '0);
  assign last     = emit && (HW'(out_row) == frame_h - HW'(1)) &&
                    (CW'(out_col) == frame_w - CW'(1));
  assign col_wrap = CW'(vcol) == frame_w - CW'(1);
  assign fwd_next = s1_valid && (s1_addr == vcol);

  always_ff @(posedge clk) begin
    if (rst || size_write) begin
      vcol        <= '0;
      vrow        <= '0;
      out_col     <= '0;
      out_row     <= '0;
      set_counter <= '0;
    end else if (take) begin
      if (last) begin
        vcol        <= '0;
        vrow        <= '0;
        out_col     <= '0;
        out_row     <= '0;
        set_counter <= '0;
      end else begin
        set_counter <= set_counter + 17'(set_now);
        if (col_wrap) begin
          vcol <= '0;
          vrow <= vrow + RW'(1);
        end else begin
          vcol <= vcol + XW'(1);
        end
        if (emit) begin
          if (CW'(out_col) == frame_w - CW'(1)) begin
            out_col <= '0;
            out_row <= out_row + ORW'(1);
          end else begin
            out_col <= out_col + XW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_set      <= set_now;
      s1_addr     <= vcol;
      s1_emit     <= emit;
      s1_last     <= last;
      s1_col      <= 8'(out_col);
      s1_row      <= 8'(out_row);
      s1_total    <= last ? set_counter : '0;
      s1_left     <= out_col == '0;
      s1_right    <= CW'(out_col) == frame_w - CW'(1);
      s1_top      <= out_row == '0;
      s1_bottom   <= HW'(out_row) == frame_h - HW'(1);
      s1_fwd      <= fwd_next;
      s1_fwd_data <= mem_wdata;
    end
  end

  // ---------------- line memory ----------------
  always_ff @(posedge clk) begin
    if (take) begin
      mem_rdata <= line_mem[vcol];
    end
    if (s1_valid) begin
      line_mem[s1_addr] <= mem_wdata;
    end
  end

  // ---------------- stage 1: window and count ----------------
  // write in the previous cycle to the same column is not yet visible in the read
  assign rd        = s1_fwd ? s1_fwd_data : mem_rdata;
  assign new_col   = {s1_set, rd};          // {row y, row y-1, row y-2}
  assign mem_wdata = {s1_set, rd[1]};

  assign row_mask = {~s1_bottom, 1'b1, ~s1_top};
  assign lm       = s1_left  ? 3'b000 : (col_p2 & row_mask);
  assign rm       = s1_right ? 3'b000 : (new_col & row_mask);
  assign mm       = col_p1 & row_mask;
  assign own      = col_p1[1];
  assign nb_count = 4'(lm[0]) + 4'(lm[1]) + 4'(lm[2]) + 4'(rm[0]) + 4'(rm[1]) +
                    4'(rm[2]) + 4'(mm[0]) + 4'(mm[2]);

  always_comb begin
    res.cell_set        = own;
    res.neighbour_count = own ? 4'd0 : nb_count;
    res.cell_col        = s1_col;
    res.cell_row        = s1_row;
    res.frame_last      = s1_last;
    res.set_total       = s1_total;
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      col_p2 <= col_p1;
      col_p1 <= new_col;
    end
  end

  // ---------------- result queue ----------------
  // space is reserved for the item in stage 1, so a push never waits
  assign push         = s1_valid && s1_emit;
  assign pop          = result_valid && result_ready;
  assign result_valid = q_count != 2'd0;
  assign result       = fifo[rd_ptr];
  assign pixel_ready  = (3'(q_count) + 3'(push)) < 3'd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == 2'd2) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == 2'd2) ? 2'd0 : rd_ptr + 2'd1;
      end
      q_count <= q_count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= res;
    end
  end

  // ---------------- assertions ----------------
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> q_count < 2'd3)
    else $error("result queue overflow");

  a_fwd_same_col: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_fwd |-> $past(s1_valid) && s1_addr == $past(s1_addr))
    else $error("forwarding without a write to the same column");

  a_set_no_count: assert property (@(posedge clk) disable iff (rst)
    push && res.cell_set |-> res.neighbour_count == 4'd0)
    else $error("set cell reports neighbours");

  a_total_on_last: assert property (@(posedge clk) disable iff (rst)
    push && !res.frame_last |-> res.set_total == '0)
    else $error("set total outside frame end");

endmodule
